// ----- src/sva_pkg.sv -----
// shared types and constants for the sound voice allocator
package sva_pkg;

   localparam logic [1:0] KIND_START    = 2'd0;
   localparam logic [1:0] KIND_STOP     = 2'd1;
   localparam logic [1:0] KIND_STOP_ALL = 2'd2;

   localparam logic [3:0]  CHAN_NONE = 4'h0;
   localparam logic [3:0]  CHAN_ANY  = 4'hF;
   localparam logic [31:0] LIFE_MAX  = 32'h7fff_ffff;

   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 8;
   localparam int VIDX_W     = 3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE,
      ST_CLEAR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] entity;
      logic [3:0]  ent_channel;
      logic [30:0] now;
      logic [23:0] length;
      logic        playable;
   } req_item_type;

   typedef struct packed {
      logic [VIDX_W-1:0] voice_index;
      logic              picked;
      logic              playing;
      logic              stop_hit;
   } rsp_item_type;

   typedef struct packed {
      logic [15:0] entity;
      logic [3:0]  channel;
      logic [31:0] end_time;
   } voice_entry_type;

   typedef struct packed {
      logic wr_en;
      logic clear_all;
   } mem_ctl_type;

endpackage

// ----- src/sound_voice_allocator_top.sv -----
// top level of the sound voice allocator
//
//  channel | dir | handshake             | payload
//  req     | in  | req_tvalid/req_tready | tuser: kind; tdata: entity, ent_channel, now,
//          |     |                       |        length, playable
//  rsp     | out | rsp_tvalid/rsp_tready | tdata: voice_index, picked, playing, stop_hit
//
// a start or stop reads the voices one per cycle through the single memory read port
// and the shared adder/comparator; a matching voice ends the scan early, and the write
// state is skipped when no voice is written
// stop-all passes through the clear state to its result; an unknown kind goes there directly
// ready returns the cycle after the result loads
// a new result waits while the previous one stalls
// reset clears the valid bits of all voices at once, no clearing pass
module sound_voice_allocator_top #(
   parameter int NUM_VOICES = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [1:0]                        req_tuser,  // kind
   // entity[15:0], ent_channel[19:16], now[50:20], length[74:51], playable[75], zeros
   input  logic [sva_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // voice_index[2:0], picked[3], playing[4], stop_hit[5], zeros
   output logic [sva_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   localparam int IDX_W = $clog2(NUM_VOICES);

   sva_pkg::req_item_type    req_item;
   sva_pkg::rsp_item_type    rsp_item;
   sva_pkg::mem_ctl_type     mem_ctl;
   sva_pkg::voice_entry_type wr_data;
   sva_pkg::voice_entry_type rd_data;
   logic [IDX_W-1:0]         rd_addr;
   logic [IDX_W-1:0]         wr_addr;

   always_comb begin
      req_item.kind        = req_tuser;
      req_item.entity      = req_tdata[15:0];
      req_item.ent_channel = req_tdata[19:16];
      req_item.now         = req_tdata[50:20];
      req_item.length      = req_tdata[74:51];
      req_item.playable    = req_tdata[75];
   end

   assign rsp_tdata = {2'b00, rsp_item.stop_hit, rsp_item.playing, rsp_item.picked,
                       rsp_item.voice_index};

   sva_ctrl #(
      .NUM_VOICES(NUM_VOICES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_item  (req_item),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_item  (rsp_item),
      .mem_ctl   (mem_ctl),
      .rd_addr   (rd_addr),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_data   (rd_data)
   );

   sva_voice_mem #(
      .NUM_VOICES(NUM_VOICES)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mem_ctl),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

endmodule

// ----- src/sva_voice_mem.sv -----
// voice table memory with one read and one write port and per-voice valid bits
module sva_voice_mem #(
   parameter int NUM_VOICES = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  sva_pkg::mem_ctl_type            ctl,
   input  logic [$clog2(NUM_VOICES)-1:0]   rd_addr,
   input  logic [$clog2(NUM_VOICES)-1:0]   wr_addr,
   input  sva_pkg::voice_entry_type        wr_data,
   output sva_pkg::voice_entry_type        rd_data
);

   sva_pkg::voice_entry_type mem [NUM_VOICES];
   sva_pkg::voice_entry_type rd_word_ff;
   logic                     rd_valid_ff;
   logic [NUM_VOICES-1:0]    valid_ff;
   logic [NUM_VOICES-1:0]    valid_in;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_word_ff <= mem[rd_addr];
   end

   always_comb begin
      valid_in = valid_ff;
      if (ctl.clear_all) begin
         valid_in = '0;
      end else if (ctl.wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // a voice never written since reset or stop-all reads as all zeros
   assign rd_data = rd_valid_ff ? rd_word_ff : '0;

endmodule

// ----- src/sva_ctrl.sv -----
// scan sequencer with the shared 32-bit add/compare unit
module sva_ctrl #(
   parameter int NUM_VOICES = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  sva_pkg::req_item_type           req_item,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output sva_pkg::rsp_item_type           rsp_item,
   output sva_pkg::mem_ctl_type            mem_ctl,
   output logic [$clog2(NUM_VOICES)-1:0]   rd_addr,
   output logic [$clog2(NUM_VOICES)-1:0]   wr_addr,
   output sva_pkg::voice_entry_type        wr_data,
   input  sva_pkg::voice_entry_type        rd_data
);

   localparam int IDX_W  = $clog2(NUM_VOICES);
   localparam int CNT_W  = $clog2(NUM_VOICES + 1);
   localparam int WIDE_W = (IDX_W > sva_pkg::VIDX_W) ? IDX_W : sva_pkg::VIDX_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_VOICES - 1);

   sva_pkg::state_type    state_ff, state_in;
   sva_pkg::req_item_type item_ff, item_in;
   logic [CNT_W-1:0]      rd_cnt_ff, rd_cnt_in;
   logic                  ev_vld_ff, ev_vld_in;
   logic [IDX_W-1:0]      ev_idx_ff, ev_idx_in;
   logic [31:0]           best_ff, best_in;
   logic [IDX_W-1:0]      victim_ff, victim_in;
   logic                  found_ff, found_in;
   sva_pkg::rsp_item_type rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                  accept;
   logic                  scanning;
   logic                  writing;
   logic                  load_rsp;
   logic                  issue;
   logic                  is_start;
   logic                  ent_eq;
   logic                  chan_eq;
   logic                  is_match;
   logic [31:0]           op_a;
   logic [31:0]           op_b;
   logic                  sub;
   logic [31:0]           sum;
   logic                  less;
   logic                  last_eval;
   logic [WIDE_W-1:0]     victim_wide;

   // shared unit: end - now during the scan, now + length at the write
   always_comb begin
      sub  = !writing;
      op_a = writing ? {1'b0, item_ff.now} : rd_data.end_time;
      op_b = writing ? {8'd0, item_ff.length} : ~{1'b0, item_ff.now};
      sum  = op_a + op_b + {31'd0, sub};
      less = $signed(sum) < $signed(best_ff);
   end

   always_comb begin
      is_start  = item_ff.kind == sva_pkg::KIND_START;
      ent_eq    = rd_data.entity == item_ff.entity;
      chan_eq   = rd_data.channel == item_ff.ent_channel;
      if (is_start) begin
         is_match = (item_ff.ent_channel != sva_pkg::CHAN_NONE) && ent_eq &&
                    (chan_eq || item_ff.ent_channel == sva_pkg::CHAN_ANY);
      end else begin
         is_match = ent_eq && chan_eq;
      end
      last_eval = ev_idx_ff == LAST_IDX;
      issue     = scanning && (rd_cnt_ff < CNT_W'(NUM_VOICES));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sva_pkg::ST_IDLE: begin
            if (req_valid) begin
               priority if (req_item.kind == sva_pkg::KIND_START ||
                            req_item.kind == sva_pkg::KIND_STOP) begin
                  state_in = sva_pkg::ST_SCAN;
               end else if (req_item.kind == sva_pkg::KIND_STOP_ALL) begin
                  state_in = sva_pkg::ST_CLEAR;
               end else begin
                  state_in = sva_pkg::ST_DONE;
               end
            end
         end
         sva_pkg::ST_SCAN: begin
            if (ev_vld_ff) begin
               if (is_match) begin
                  state_in = sva_pkg::ST_WRITE;
               end else if (last_eval) begin
                  if (found_ff || (is_start && less)) begin
                     state_in = sva_pkg::ST_WRITE;
                  end else begin
                     state_in = sva_pkg::ST_DONE;
                  end
               end
            end
         end
         sva_pkg::ST_WRITE: state_in = sva_pkg::ST_DONE;
         sva_pkg::ST_CLEAR: state_in = sva_pkg::ST_DONE;
         sva_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = sva_pkg::ST_IDLE;
            end
         end
         default: state_in = sva_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready         = 1'b0;
      scanning          = 1'b0;
      writing           = 1'b0;
      load_rsp          = 1'b0;
      mem_ctl.wr_en     = 1'b0;
      mem_ctl.clear_all = 1'b0;
      unique case (state_ff)
         sva_pkg::ST_IDLE:  req_ready = 1'b1;
         sva_pkg::ST_SCAN:  scanning = 1'b1;
         sva_pkg::ST_WRITE: begin
            writing       = 1'b1;
            mem_ctl.wr_en = 1'b1;
         end
         sva_pkg::ST_CLEAR: mem_ctl.clear_all = 1'b1;
         sva_pkg::ST_DONE:  load_rsp = !rsp_valid_ff || rsp_ready;
         default: req_ready = 1'b0;
      endcase
   end

   assign accept = req_valid && req_ready;

   // scan bookkeeping
   always_comb begin
      item_in   = item_ff;
      rd_cnt_in = rd_cnt_ff;
      ev_vld_in = issue;
      ev_idx_in = rd_cnt_ff[IDX_W-1:0];
      best_in   = best_ff;
      victim_in = victim_ff;
      found_in  = found_ff;
      if (accept) begin
         item_in   = req_item;
         rd_cnt_in = '0;
         ev_vld_in = 1'b0;
         best_in   = sva_pkg::LIFE_MAX;
         victim_in = '0;
         found_in  = 1'b0;
      end else if (scanning) begin
         if (issue) begin
            rd_cnt_in = rd_cnt_ff + CNT_W'(1);
         end
         if (ev_vld_ff) begin
            if (is_match) begin
               victim_in = ev_idx_ff;
               found_in  = 1'b1;
            end else if (is_start && less) begin
               best_in   = sum;
               victim_in = ev_idx_ff;
               found_in  = 1'b1;
            end
         end
      end
   end

   assign rd_addr          = rd_cnt_ff[IDX_W-1:0];
   assign wr_addr          = victim_ff;
   assign wr_data.entity   = item_ff.entity;
   assign wr_data.channel  = item_ff.ent_channel;
   assign wr_data.end_time = (is_start && item_ff.playable) ? sum : 32'd0;

   // result register, free again as soon as the waiting result transfers
   always_comb begin
      victim_wide        = WIDE_W'(victim_ff);
      rsp_in             = rsp_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_ready;
      if (load_rsp) begin
         rsp_in.voice_index = found_ff ? victim_wide[sva_pkg::VIDX_W-1:0] : '0;
         rsp_in.picked      = is_start && found_ff;
         rsp_in.playing     = is_start && found_ff && item_ff.playable;
         rsp_in.stop_hit    = (item_ff.kind == sva_pkg::KIND_STOP) && found_ff;
         rsp_valid_in       = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sva_pkg::ST_IDLE;
         rd_cnt_ff    <= '0;
         ev_vld_ff    <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_cnt_ff    <= rd_cnt_in;
         ev_vld_ff    <= ev_vld_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      ev_idx_ff <= ev_idx_in;
      best_ff   <= best_in;
      victim_ff <= victim_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// ----- src/sva_checker.sv -----
// port-level checks for the sound voice allocator, bound to the top level
module sva_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [sva_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // one request at a time: busy right after a transfer
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready right after a request transfer");

   // nothing left over from before reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid just after reset");

   // playing implies picked, and a picked result never reports a stop hit
   a_rsp_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tdata[4] || rsp_tdata[3]) && !(rsp_tdata[3] && rsp_tdata[5]))
      else $error("inconsistent result flags");

endmodule

bind sound_voice_allocator_top sva_checker u_sva_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
